@@ sv/i2cm_pkg.sv @@
// Shared types and constants for the timed I2C bit-level master.
`default_nettype none

package i2cm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = 4;
  localparam int HOLD_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd4;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_STOP  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HOLD = 2'd0,
    CFG_STOP_HOLD  = 2'd1,
    CFG_BIT_HOLD   = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_A      = 5'd1,
    PH_ST_B      = 5'd2,
    PH_ST_C      = 5'd3,
    PH_WR_LO     = 5'd4,
    PH_WR_HI     = 5'd5,
    PH_WR_ACK_LO = 5'd6,
    PH_WR_ACK_HI = 5'd7,
    PH_WR_END    = 5'd8,
    PH_RD_LO     = 5'd9,
    PH_RD_HI     = 5'd10,
    PH_RD_ACK_LO = 5'd11,
    PH_RD_ACK_HI = 5'd12,
    PH_RD_END    = 5'd13,
    PH_SP_A      = 5'd14,
    PH_SP_B      = 5'd15,
    PH_SP_C      = 5'd16
  } phase_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       ack_level;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_item_t;

  // Line levels plus the hold count loaded on entry to a phase.
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              drv;
    logic [HOLD_W-1:0] hold;
  } lines_t;

endpackage

`default_nettype wire

@@ sv/i2c_bit_level_master.sv @@
// Top level of the timed I2C bit-level master.
//
// Usage:
//   in_*  : one transaction per bus tick. A command (start, write byte, read
//           byte, stop) is taken only while no command is running; otherwise
//           the tick just advances the running sequence. sda_in is the bus
//           SDA level seen on that tick.
//   out_* : one transaction per accepted tick with SCL/SDA levels, SDA drive
//           enable, busy, done, last read byte and last write ack.
//   cfg_* : hold lengths (start, stop, bit) in ticks; write only while idle.
//           cfg_ready is always high. A hold of zero acts as one tick.
// The result of a tick is registered and shows the cycle after acceptance.
// Throughput is one tick per cycle while out_stall is low, set by the single
// result register; all per-tick work is one pass of next-state logic.
// in_stall rises only while a result is held and out_stall is high, so a
// stalled receiver freezes the sequencer with the result intact.
// Reset (rst_n low, synchronous) returns to idle with SCL and SDA driven
// high, holds back to four ticks, read byte and ack cleared.
`default_nettype none

module i2c_bit_level_master (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  i2cm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output i2cm_pkg::out_item_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HW = i2cm_pkg::HOLD_W;
  localparam int BW = i2cm_pkg::BIT_CNT_W;

  // Configuration.
  logic [HW-1:0] start_hold_r, stop_hold_r, bit_hold_r;

  // Sequencer state.
  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [BW-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [HW-1:0]    hold_r, hold_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             ack_hold_r, ack_hold_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;
  logic             drv_r, drv_nxt;
  logic             ack_r, ack_nxt;
  logic [7:0]       rd_res_r, rd_res_nxt;

  // Result register.
  logic                out_valid_r;
  i2cm_pkg::out_item_t out_data_r, out_data_nxt;

  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  function automatic logic [HW-1:0] at_least_one(input logic [HW-1:0] h);
    at_least_one = (h == '0) ? HW'(1) : h;
  endfunction

  // Line levels and hold count on entry to phase p.
  function automatic i2cm_pkg::lines_t enter_f(
    input i2cm_pkg::phase_t p,
    input i2cm_pkg::lines_t cur,
    input logic             msb,
    input logic             ack_lvl,
    input logic [HW-1:0]    st_h,
    input logic [HW-1:0]    sp_h,
    input logic [HW-1:0]    bt_h
  );
    i2cm_pkg::lines_t l;
    l = cur;
    case (p)
      i2cm_pkg::PH_ST_A: begin
        l.scl = 1'b1; l.sda = 1'b1; l.drv = 1'b1; l.hold = at_least_one(st_h);
      end
      i2cm_pkg::PH_ST_B: begin
        l.sda = 1'b0; l.hold = at_least_one(st_h);
      end
      i2cm_pkg::PH_ST_C: begin
        l.scl = 1'b0; l.hold = at_least_one(st_h);
      end
      i2cm_pkg::PH_WR_LO: begin
        l.scl = 1'b0; l.drv = 1'b1; l.sda = msb; l.hold = at_least_one(bt_h);
      end
      i2cm_pkg::PH_WR_ACK_LO, i2cm_pkg::PH_RD_LO: begin
        l.scl = 1'b0; l.drv = 1'b0; l.sda = 1'b1; l.hold = at_least_one(bt_h);
      end
      i2cm_pkg::PH_WR_HI, i2cm_pkg::PH_WR_ACK_HI,
      i2cm_pkg::PH_RD_HI, i2cm_pkg::PH_RD_ACK_HI: begin
        l.scl = 1'b1; l.hold = at_least_one(bt_h);
      end
      i2cm_pkg::PH_WR_END: begin
        l.scl = 1'b0; l.hold = at_least_one(bt_h);
      end
      i2cm_pkg::PH_RD_ACK_LO: begin
        l.scl = 1'b0; l.drv = 1'b1; l.sda = ack_lvl; l.hold = at_least_one(bt_h);
      end
      i2cm_pkg::PH_RD_END: begin
        l.scl = 1'b0; l.hold = at_least_one(sp_h);
      end
      i2cm_pkg::PH_SP_A: begin
        l.scl = 1'b0; l.sda = 1'b0; l.drv = 1'b1; l.hold = at_least_one(sp_h);
      end
      i2cm_pkg::PH_SP_B: begin
        l.scl = 1'b1; l.hold = at_least_one(sp_h);
      end
      i2cm_pkg::PH_SP_C: begin
        l.sda = 1'b1; l.hold = at_least_one(sp_h);
      end
      default: begin
        l.hold = '0;
      end
    endcase
    enter_f = l;
  endfunction

  // One tick of the sequencer: command launch, result levels, phase advance.
  always_comb begin
    i2cm_pkg::phase_t np;
    i2cm_pkg::lines_t ln;
    logic             busy;
    logic             done;

    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    hold_nxt     = hold_r;
    shift_nxt    = shift_r;
    ack_hold_nxt = ack_hold_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    drv_nxt      = drv_r;
    ack_nxt      = ack_r;
    rd_res_nxt   = rd_res_r;
    np           = i2cm_pkg::PH_IDLE;
    done         = 1'b0;
    ln           = '{scl: scl_r, sda: sda_r, drv: drv_r, hold: hold_r};

    // Launch a command only from idle; unknown codes act as a plain tick.
    if (phase_r == i2cm_pkg::PH_IDLE &&
        in_data.cmd inside {[i2cm_pkg::CMD_START:i2cm_pkg::CMD_STOP]}) begin
      bit_cnt_nxt = '0;
      case (in_data.cmd)
        i2cm_pkg::CMD_START: np = i2cm_pkg::PH_ST_A;
        i2cm_pkg::CMD_WRITE: begin
          shift_nxt = in_data.data_byte;
          np        = i2cm_pkg::PH_WR_LO;
        end
        i2cm_pkg::CMD_READ: begin
          shift_nxt    = '0;
          ack_hold_nxt = in_data.ack_level;
          np           = i2cm_pkg::PH_RD_LO;
        end
        default: np = i2cm_pkg::PH_SP_A;
      endcase
      phase_nxt = np;
      ln = enter_f(np, ln, shift_nxt[7], ack_hold_nxt,
                   start_hold_r, stop_hold_r, bit_hold_r);
    end

    busy = (phase_nxt != i2cm_pkg::PH_IDLE);
    out_data_nxt.scl_level = ln.scl;
    out_data_nxt.sda_level = ln.sda;
    out_data_nxt.sda_drive = ln.drv;

    if (busy) begin
      ln.hold = ln.hold - HW'(1);
      if (ln.hold == '0) begin
        case (phase_nxt)
          i2cm_pkg::PH_ST_A:      np = i2cm_pkg::PH_ST_B;
          i2cm_pkg::PH_ST_B:      np = i2cm_pkg::PH_ST_C;
          i2cm_pkg::PH_WR_LO:     np = i2cm_pkg::PH_WR_HI;
          i2cm_pkg::PH_WR_HI: begin
            shift_nxt   = {shift_nxt[6:0], 1'b0};
            bit_cnt_nxt = bit_cnt_nxt + BW'(1);
            np = (bit_cnt_nxt >= BW'(i2cm_pkg::BITS_PER_BYTE)) ?
                 i2cm_pkg::PH_WR_ACK_LO : i2cm_pkg::PH_WR_LO;
          end
          i2cm_pkg::PH_WR_ACK_LO: np = i2cm_pkg::PH_WR_ACK_HI;
          i2cm_pkg::PH_WR_ACK_HI: begin
            ack_nxt = in_data.sda_in;
            np      = i2cm_pkg::PH_WR_END;
          end
          i2cm_pkg::PH_RD_LO:     np = i2cm_pkg::PH_RD_HI;
          i2cm_pkg::PH_RD_HI: begin
            shift_nxt   = {shift_nxt[6:0], in_data.sda_in};
            bit_cnt_nxt = bit_cnt_nxt + BW'(1);
            if (bit_cnt_nxt >= BW'(i2cm_pkg::BITS_PER_BYTE)) begin
              rd_res_nxt = shift_nxt;
              np         = i2cm_pkg::PH_RD_ACK_LO;
            end else begin
              np = i2cm_pkg::PH_RD_LO;
            end
          end
          i2cm_pkg::PH_RD_ACK_LO: np = i2cm_pkg::PH_RD_ACK_HI;
          i2cm_pkg::PH_RD_ACK_HI: np = i2cm_pkg::PH_RD_END;
          i2cm_pkg::PH_SP_A:      np = i2cm_pkg::PH_SP_B;
          i2cm_pkg::PH_SP_B:      np = i2cm_pkg::PH_SP_C;
          default:                np = i2cm_pkg::PH_IDLE;
        endcase
        phase_nxt = np;
        ln = enter_f(np, ln, shift_nxt[7], ack_hold_nxt,
                     start_hold_r, stop_hold_r, bit_hold_r);
        done = (np == i2cm_pkg::PH_IDLE);
      end
    end

    hold_nxt = ln.hold;
    scl_nxt  = ln.scl;
    sda_nxt  = ln.sda;
    drv_nxt  = ln.drv;

    out_data_nxt.busy_res  = busy;
    out_data_nxt.done_res  = done;
    out_data_nxt.read_byte = rd_res_nxt;
    out_data_nxt.ack_seen  = ack_nxt;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_hold_r <= i2cm_pkg::HOLD_RESET;
      stop_hold_r  <= i2cm_pkg::HOLD_RESET;
      bit_hold_r   <= i2cm_pkg::HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        i2cm_pkg::CFG_START_HOLD: start_hold_r <= cfg_data;
        i2cm_pkg::CFG_STOP_HOLD:  stop_hold_r  <= cfg_data;
        i2cm_pkg::CFG_BIT_HOLD:   bit_hold_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cm_pkg::PH_IDLE;
      bit_cnt_r  <= '0;
      hold_r     <= '0;
      shift_r    <= '0;
      ack_hold_r <= 1'b0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      drv_r      <= 1'b1;
      ack_r      <= 1'b0;
      rd_res_r   <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      hold_r     <= hold_nxt;
      shift_r    <= shift_nxt;
      ack_hold_r <= ack_hold_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      drv_r      <= drv_nxt;
      ack_r      <= ack_nxt;
      rd_res_r   <= rd_res_nxt;
    end
  end

  // Result register: loads on accept, drains when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/i2cm_checker.sv @@
// Port-level checker for the I2C bit-level master, bound to the top level.
`default_nettype none

module i2cm_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_stall,
  input wire                                 out_valid,
  input wire                                 out_stall,
  input i2cm_pkg::out_item_t                 out_data
);

  // A held result stays put while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No tick taken while a result is stuck in the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted over a stalled result");

  // Completion tick belongs to the command.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done without busy");

  // Released SDA always reads high.
  a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.sda_drive |-> out_data.sda_level)
    else $error("SDA released but level low");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind i2c_bit_level_master i2cm_checker u_i2cm_checker (.*);

`default_nettype wire

@@ tb/i2cm_line_checker.sv @@
// Line-level predictor and result checker for the timed I2C bit-level master.
module i2cm_line_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  input  wire                                 in_stall,
  input  i2cm_pkg::in_item_t                  in_data,
  input  wire                                 out_valid,
  input  wire                                 out_stall,
  input  i2cm_pkg::out_item_t                 out_data,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_ready,
  input  wire  [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  fail_count,
  output int                                  results_owed,
  output logic                                bus_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 100;
  localparam int HW        = i2cm_pkg::HOLD_W;
  localparam int BW        = i2cm_pkg::BIT_CNT_W;

  // Hold lengths as last written
  logic [HW-1:0]        start_hold, stop_hold, bit_hold;

  // Sequencer copy
  i2cm_pkg::phase_t     ph;
  logic [BW-1:0]        bits_done;
  logic [HW-1:0]        ticks_left;
  logic [7:0]           shreg;
  logic [7:0]           last_read;
  logic                 ack_drive;
  logic                 scl_q, sda_q, drv_q, ack_q;

  i2cm_pkg::out_item_t  due_levels[$];
  int                   fails;

  function automatic logic [HW-1:0] hold_len(input logic [HW-1:0] h);
    return (h == '0) ? HW'(1) : h;
  endfunction

  task enter_phase(input i2cm_pkg::phase_t p);
    ph = p;
    case (p)
      i2cm_pkg::PH_ST_A: begin
        scl_q = 1'b1; sda_q = 1'b1; drv_q = 1'b1;
        ticks_left = hold_len(start_hold);
      end
      i2cm_pkg::PH_ST_B: begin
        sda_q = 1'b0;
        ticks_left = hold_len(start_hold);
      end
      i2cm_pkg::PH_ST_C: begin
        scl_q = 1'b0;
        ticks_left = hold_len(start_hold);
      end
      i2cm_pkg::PH_WR_LO: begin
        scl_q = 1'b0; drv_q = 1'b1; sda_q = shreg[7];
        ticks_left = hold_len(bit_hold);
      end
      i2cm_pkg::PH_WR_ACK_LO, i2cm_pkg::PH_RD_LO: begin
        scl_q = 1'b0; drv_q = 1'b0; sda_q = 1'b1;
        ticks_left = hold_len(bit_hold);
      end
      i2cm_pkg::PH_WR_HI, i2cm_pkg::PH_WR_ACK_HI,
      i2cm_pkg::PH_RD_HI, i2cm_pkg::PH_RD_ACK_HI: begin
        scl_q = 1'b1;
        ticks_left = hold_len(bit_hold);
      end
      i2cm_pkg::PH_WR_END: begin
        scl_q = 1'b0;
        ticks_left = hold_len(bit_hold);
      end
      i2cm_pkg::PH_RD_ACK_LO: begin
        scl_q = 1'b0; drv_q = 1'b1; sda_q = ack_drive;
        ticks_left = hold_len(bit_hold);
      end
      i2cm_pkg::PH_RD_END: begin
        scl_q = 1'b0;
        ticks_left = hold_len(stop_hold);
      end
      i2cm_pkg::PH_SP_A: begin
        scl_q = 1'b0; sda_q = 1'b0; drv_q = 1'b1;
        ticks_left = hold_len(stop_hold);
      end
      i2cm_pkg::PH_SP_B: begin
        scl_q = 1'b1;
        ticks_left = hold_len(stop_hold);
      end
      i2cm_pkg::PH_SP_C: begin
        sda_q = 1'b1;
        ticks_left = hold_len(stop_hold);
      end
      default: begin
        ph = i2cm_pkg::PH_IDLE;
        ticks_left = '0;
      end
    endcase
  endtask

  // One bus tick: levels shown are those of the phase the tick belongs to
  task advance_bus(input i2cm_pkg::in_item_t t, output i2cm_pkg::out_item_t r);
    i2cm_pkg::phase_t nxt;
    r = '0;
    if (ph == i2cm_pkg::PH_IDLE) begin
      case (t.cmd)
        i2cm_pkg::CMD_START: begin
          bits_done = '0;
          enter_phase(i2cm_pkg::PH_ST_A);
        end
        i2cm_pkg::CMD_WRITE: begin
          bits_done = '0;
          shreg = t.data_byte;
          enter_phase(i2cm_pkg::PH_WR_LO);
        end
        i2cm_pkg::CMD_READ: begin
          bits_done = '0;
          shreg = '0;
          ack_drive = t.ack_level;
          enter_phase(i2cm_pkg::PH_RD_LO);
        end
        i2cm_pkg::CMD_STOP: begin
          bits_done = '0;
          enter_phase(i2cm_pkg::PH_SP_A);
        end
        default: ;
      endcase
    end
    r.busy_res  = (ph != i2cm_pkg::PH_IDLE);
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = drv_q;
    if (r.busy_res) begin
      ticks_left = ticks_left - 1'b1;
      if (ticks_left == '0) begin
        case (ph)
          i2cm_pkg::PH_ST_A:      nxt = i2cm_pkg::PH_ST_B;
          i2cm_pkg::PH_ST_B:      nxt = i2cm_pkg::PH_ST_C;
          i2cm_pkg::PH_WR_LO:     nxt = i2cm_pkg::PH_WR_HI;
          i2cm_pkg::PH_WR_HI: begin
            shreg = {shreg[6:0], 1'b0};
            bits_done = bits_done + 1'b1;
            nxt = (bits_done >= i2cm_pkg::BITS_PER_BYTE) ?
                  i2cm_pkg::PH_WR_ACK_LO : i2cm_pkg::PH_WR_LO;
          end
          i2cm_pkg::PH_WR_ACK_LO: nxt = i2cm_pkg::PH_WR_ACK_HI;
          i2cm_pkg::PH_WR_ACK_HI: begin
            ack_q = t.sda_in;
            nxt = i2cm_pkg::PH_WR_END;
          end
          i2cm_pkg::PH_RD_LO:     nxt = i2cm_pkg::PH_RD_HI;
          i2cm_pkg::PH_RD_HI: begin
            shreg = {shreg[6:0], t.sda_in};
            bits_done = bits_done + 1'b1;
            if (bits_done >= i2cm_pkg::BITS_PER_BYTE) begin
              last_read = shreg;
              nxt = i2cm_pkg::PH_RD_ACK_LO;
            end else begin
              nxt = i2cm_pkg::PH_RD_LO;
            end
          end
          i2cm_pkg::PH_RD_ACK_LO: nxt = i2cm_pkg::PH_RD_ACK_HI;
          i2cm_pkg::PH_RD_ACK_HI: nxt = i2cm_pkg::PH_RD_END;
          i2cm_pkg::PH_SP_A:      nxt = i2cm_pkg::PH_SP_B;
          i2cm_pkg::PH_SP_B:      nxt = i2cm_pkg::PH_SP_C;
          default:                nxt = i2cm_pkg::PH_IDLE;
        endcase
        enter_phase(nxt);
        r.done_res = (nxt == i2cm_pkg::PH_IDLE);
      end
    end
    r.read_byte = last_read;
    r.ack_seen  = ack_q;
  endtask

  task check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (fails < PRINT_CAP)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    i2cm_pkg::out_item_t want;
    i2cm_pkg::out_item_t fresh;
    if (!rst_n) begin
      start_hold = i2cm_pkg::HOLD_RESET;
      stop_hold  = i2cm_pkg::HOLD_RESET;
      bit_hold   = i2cm_pkg::HOLD_RESET;
      ph         = i2cm_pkg::PH_IDLE;
      bits_done  = '0;
      ticks_left = '0;
      shreg      = '0;
      last_read  = '0;
      ack_drive  = 1'b0;
      scl_q      = 1'b1;
      sda_q      = 1'b1;
      drv_q      = 1'b1;
      ack_q      = 1'b0;
      fails      = 0;
      due_levels.delete();
    end else begin
      // results are registered behind their tick, so compare before queuing this edge's tick
      if (out_valid && !out_stall) begin
        if (due_levels.size() == 0) begin
          if (fails < PRINT_CAP)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fails++;
        end else begin
          want = due_levels.pop_front();
          check_field("scl_level", want.scl_level, out_data.scl_level);
          check_field("sda_level", want.sda_level, out_data.sda_level);
          check_field("sda_drive", want.sda_drive, out_data.sda_drive);
          check_field("busy_res",  want.busy_res,  out_data.busy_res);
          check_field("done_res",  want.done_res,  out_data.done_res);
          check_field("read_byte", want.read_byte, out_data.read_byte);
          check_field("ack_seen",  want.ack_seen,  out_data.ack_seen);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          i2cm_pkg::CFG_START_HOLD: start_hold = cfg_data;
          i2cm_pkg::CFG_STOP_HOLD:  stop_hold  = cfg_data;
          i2cm_pkg::CFG_BIT_HOLD:   bit_hold   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_bus(in_data, fresh);
        due_levels.push_back(fresh);
      end
    end
    fail_count   <= fails;
    results_owed <= due_levels.size();
    bus_busy     <= (ph != i2cm_pkg::PH_IDLE);
  end

endmodule

@@ tb/tb_i2c_bit_level_master.sv @@
// Testbench top for the timed I2C bit-level master: stimulus, bus pacing and verdict.
module tb_i2c_bit_level_master;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PERIOD        = 4;
  localparam int         RESET_CYCLES  = 6;
  localparam int         GAP_MAX       = 12;
  localparam int         RANDOM_TICKS  = 150;
  localparam int         SETTLE_CYCLES = 10;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam logic [2:0] CMD_MAX       = 3'd7;
  localparam logic [7:0] HOLD_MAX      = 8'd255;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  i2cm_pkg::in_item_t   in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  i2cm_pkg::cfg_idx_t   cfg_index = i2cm_pkg::CFG_START_HOLD;
  logic [7:0]           cfg_data  = '0;

  logic                 in_stall;
  logic                 out_valid;
  i2cm_pkg::out_item_t  out_data;
  logic                 cfg_ready;

  int         fail_count;
  int         results_owed;
  logic       bus_busy;

  // Ticks waiting to go out; the driver below paces them onto the channel
  i2cm_pkg::in_item_t tick_q[$];
  int         ticks_pushed = 0;
  int         ticks_taken  = 0;
  int         hold_off     = 0;
  // No idle gaps on either side while set
  bit         quiet        = 1'b0;

  // Top's view of the hold registers, used only to size command sequences
  logic [7:0] cur_start = i2cm_pkg::HOLD_RESET;
  logic [7:0] cur_stop  = i2cm_pkg::HOLD_RESET;
  logic [7:0] cur_bit   = i2cm_pkg::HOLD_RESET;

  always #(PERIOD / 2) clk = ~clk;

  i2c_bit_level_master DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  i2cm_line_checker line_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .bus_busy     (bus_busy)
  );

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  // Tick with random payload; sda_in random so write acks and read bits vary
  function automatic i2cm_pkg::in_item_t make_tick(input logic [2:0] c);
    i2cm_pkg::in_item_t t;
    t.cmd       = c;
    t.data_byte = 8'($urandom_range(0, 255));
    t.ack_level = 1'($urandom_range(0, 1));
    t.sda_in    = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // Ticks a command keeps the sequencer busy, the command tick included
  function automatic int seq_ticks(input logic [2:0] c);
    int s, p, b;
    s = (cur_start == '0) ? 1 : cur_start;
    p = (cur_stop == '0) ? 1 : cur_stop;
    b = (cur_bit == '0) ? 1 : cur_bit;
    case (c)
      i2cm_pkg::CMD_START: return 3 * s;
      i2cm_pkg::CMD_WRITE: return 19 * b;     // 8 bits low/high, ack low/high, trailing low
      i2cm_pkg::CMD_READ:  return 18 * b + p; // 8 bits, ack clock, then stop-length low
      i2cm_pkg::CMD_STOP:  return 3 * p;
      default:             return 1;
    endcase
  endfunction

  // Mostly short holds; a zero now and then, a longer one rarely
  function automatic logic [7:0] pick_hold();
    case ($urandom_range(0, 7))
      0:       return '0;
      7:       return 8'($urandom_range(3, 9));
      default: return 8'($urandom_range(1, 2));
    endcase
  endfunction

  task push_tick(input i2cm_pkg::in_item_t t);
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  // Command tick, exactly enough ticks to carry it to done, then up to two plain ticks.
  // Some of the former carry a command of their own, which the busy block must ignore.
  task issue(input logic [2:0] c, input logic [7:0] data, input logic ack);
    i2cm_pkg::in_item_t it;
    it = make_tick(c);
    it.data_byte = data;
    it.ack_level = ack;
    push_tick(it);
    repeat (seq_ticks(c) - 1)
      push_tick(make_tick(($urandom_range(0, 7) == 0) ?
                          3'($urandom_range(0, CMD_MAX)) : i2cm_pkg::CMD_TICK));
    repeat ($urandom_range(0, 2)) push_tick(make_tick(i2cm_pkg::CMD_TICK));
  endtask

  task write_reg(input i2cm_pkg::cfg_idx_t idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // All three holds back to back; valid stays up across the writes
  task program_holds(input logic [7:0] s, input logic [7:0] p, input logic [7:0] b);
    cur_start = s;
    cur_stop  = p;
    cur_bit   = b;
    write_reg(i2cm_pkg::CFG_START_HOLD, s);
    write_reg(i2cm_pkg::CFG_STOP_HOLD, p);
    write_reg(i2cm_pkg::CFG_BIT_HOLD, b);
    cfg_valid <= 1'b0;
  endtask

  // Block until every tick is taken, every result is in and the sequencer
  // is back to idle. Plain ticks are fed if a command is still running.
  // All status read here is registered, so values seen at an edge describe
  // the same earlier edges.
  task wait_bus_idle();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      @(posedge clk);
      if (ticks_taken == ticks_pushed && results_owed == 0) begin
        if (!bus_busy) settled = 1'b1;
        else push_tick(make_tick(i2cm_pkg::CMD_TICK));
      end
    end
  endtask

  task run_session();
    if ($urandom_range(0, 4) == 0) begin
      // broken order: any codes, unknown ones included
      repeat ($urandom_range(1, 4))
        issue(3'($urandom_range(0, CMD_MAX)), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
    end else begin
      issue(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0)
          issue(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
        issue($urandom_range(0, 1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_READ,
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      issue(i2cm_pkg::CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Input side: one tick per transaction, random hold-off between ticks.
  // Valid drops only for a gap or when nothing is queued.
  initial begin : tick_driver
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) ticks_taken <= ticks_taken + 1;
      if (!(in_valid && in_stall)) begin
        if (hold_off > 0) begin
          hold_off--;
          in_valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
          hold_off = draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: stall a random number of cycles, then take one result
  initial begin : result_stall
    int n;
    forever begin
      n = draw_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int burst_base;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset holds: every command, unknown codes, and commands
    // landing while busy via issue()
    issue(i2cm_pkg::CMD_TICK, 8'h00, 1'b0);
    issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
    issue(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0);
    issue(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
    issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    for (int c = i2cm_pkg::CMD_STOP + 1; c <= CMD_MAX; c++)
      issue(3'(c), 8'h5A, 1'b1);
    wait_bus_idle();

    // Zero holds act as one tick per phase; byte extremes, both ack levels
    program_holds('0, '0, '0);
    issue(i2cm_pkg::CMD_START, 8'h00, 1'b0);
    issue(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0);
    issue(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1);
    issue(i2cm_pkg::CMD_READ, 8'h00, 1'b0);
    issue(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
    issue(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    wait_bus_idle();

    // Longest stop hold after a fast read ack clock
    program_holds('0, HOLD_MAX, 8'd1);
    issue(i2cm_pkg::CMD_READ, 8'h00, 1'($urandom_range(0, 1)));
    wait_bus_idle();

    // Random: new holds each round, mostly well-formed start/data/stop sessions
    burst_base = ticks_pushed;
    while (ticks_pushed - burst_base < RANDOM_TICKS) begin
      program_holds(pick_hold(), pick_hold(), pick_hold());
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) run_session();
      wait_bus_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ i2c_bit_level_master.f @@
sv/i2cm_pkg.sv
sv/i2c_bit_level_master.sv
sv/i2cm_checker.sv
tb/i2cm_line_checker.sv
tb/tb_i2c_bit_level_master.sv
